// ----- rtl/ptri_pkg.sv -----
// Shared constants and types for the planar trilateration block.
// No dependencies; the top level imports it.
`default_nettype none

package ptri_pkg;

    // Default width of one distance.
    localparam int DIST_BITS_DEF = 16;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_BASE = 2'd1,
        ST_NO_CROSS  = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/planar_trilateration.sv -----
// Planar trilateration: two-circle intersection, fully pipelined.
// The pipeline length is set by one square root stage per root bit and one divider
// stage per quotient bit. Throughput is one word per cycle; a stall on the result side
// freezes the whole pipeline.
// Reset (aresetn, synchronous, active low) clears every valid bit; data is not reset.
// Depends on ptri_pkg.
`default_nettype none

module planar_trilateration #(
    parameter int DIST_BITS = ptri_pkg::DIST_BITS_DEF,
    localparam int S_DATA_W = ((3 * DIST_BITS + 7) / 8) * 8,
    localparam int M_DATA_W = ((2 * DIST_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // tdata from bit 0: baseline, range_from_origin, range_from_axis
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // tdata from bit 0: pos_x, pos_y
    output logic [M_DATA_W-1:0]      m_tdata,
    // tuser: status
    output logic [1:0]               m_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready
);
    import ptri_pkg::*;

    localparam int W    = DIST_BITS;
    localparam int FW   = W + 2;          // triangle factors, signed
    localparam int PW   = 2 * FW;         // factor products
    localparam int DW   = 2 * PW;         // discriminant
    localparam int RW   = PW;             // square root
    localparam int RMW  = RW + 2;         // square root remainder
    localparam int NW   = 2 * W + 2;      // signed x numerator
    localparam int XMW  = 2 * W + 1;      // numerator magnitude
    localparam int PAD  = M_DATA_W - (2 * W + 1);

    // Global pipeline advance.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Input fields.
    logic [W-1:0] in_a, in_b, in_c;
    assign in_a = s_tdata[W-1:0];
    assign in_b = s_tdata[2*W-1:W];
    assign in_c = s_tdata[3*W-1:2*W];

    // Stage 1: squares, perimeter sum and triangle factors.
    logic              v1_reg;
    logic [W-1:0]      a1_reg;
    logic [2*W-1:0]    a2_reg, b2_reg, c2_reg;
    logic [FW-1:0]     s1_reg;
    logic signed [FW-1:0] f1_reg, f2_reg, f3_reg;
    logic signed [FW-1:0] ea, eb, ec;

    assign ea = $signed({2'b00, in_a});
    assign eb = $signed({2'b00, in_b});
    assign ec = $signed({2'b00, in_c});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
        if (en) begin
            a1_reg <= in_a;
            a2_reg <= (2*W)'(in_a) * (2*W)'(in_a);
            b2_reg <= (2*W)'(in_b) * (2*W)'(in_b);
            c2_reg <= (2*W)'(in_c) * (2*W)'(in_c);
            s1_reg <= FW'(in_a) + FW'(in_b) + FW'(in_c);
            f1_reg <= ea + eb - ec;
            f2_reg <= ea - eb + ec;
            f3_reg <= eb + ec - ea;
        end
    end

    // Stage 2: factor products, x numerator and status.
    logic                 v2_reg;
    logic [PW-1:0]        p2_reg, q2_reg;
    logic signed [NW-1:0] n2_reg;
    logic [W:0]           dv2_reg;
    status_t              st2_reg;
    status_t              st2_next;

    always_comb begin
        if (a1_reg == '0) begin
            st2_next = ST_ZERO_BASE;
        end else if (f1_reg[FW-1] || f2_reg[FW-1] || f3_reg[FW-1]) begin
            st2_next = ST_NO_CROSS;
        end else begin
            st2_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            p2_reg  <= PW'(s1_reg) * PW'(f1_reg);
            q2_reg  <= PW'(f2_reg) * PW'(f3_reg);
            n2_reg  <= $signed(NW'(a2_reg) + NW'(b2_reg) - NW'(c2_reg));
            dv2_reg <= {a1_reg, 1'b0};
            st2_reg <= st2_next;
        end
    end

    // Stage 3: partial products of the discriminant, numerator magnitude.
    logic             v3_reg;
    logic [PW-1:0]    pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic             xn3_reg;
    logic [XMW-1:0]   xm3_reg;
    logic [W:0]       dv3_reg;
    status_t          st3_reg;
    logic [NW-1:0]    n2_neg;

    assign n2_neg = -n2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            pp_ll_reg <= PW'(p2_reg[FW-1:0])  * PW'(q2_reg[FW-1:0]);
            pp_lh_reg <= PW'(p2_reg[FW-1:0])  * PW'(q2_reg[PW-1:FW]);
            pp_hl_reg <= PW'(p2_reg[PW-1:FW]) * PW'(q2_reg[FW-1:0]);
            pp_hh_reg <= PW'(p2_reg[PW-1:FW]) * PW'(q2_reg[PW-1:FW]);
            xn3_reg   <= n2_reg[NW-1];
            xm3_reg   <= n2_reg[NW-1] ? n2_neg[XMW-1:0] : XMW'(n2_reg);
            dv3_reg   <= dv2_reg;
            st3_reg   <= st2_reg;
        end
    end

    // Square root pipeline; index 0 is stage 4, which sums the partial products.
    logic           sq_v_reg    [0:RW];
    logic [DW-1:0]  sq_d_reg    [0:RW];
    logic [RMW-1:0] sq_rem_reg  [0:RW];
    logic [RW-1:0]  sq_root_reg [0:RW];
    logic           sq_xn_reg   [0:RW];
    logic [XMW-1:0] sq_xm_reg   [0:RW];
    logic [W:0]     sq_dv_reg   [0:RW];
    status_t        sq_st_reg   [0:RW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= v3_reg;
        end
        if (en) begin
            sq_d_reg[0]    <= (DW'(pp_hh_reg) << PW) + (DW'(pp_lh_reg) << FW)
                              + (DW'(pp_hl_reg) << FW) + DW'(pp_ll_reg);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_xn_reg[0]   <= xn3_reg;
            sq_xm_reg[0]   <= xm3_reg;
            sq_dv_reg[0]   <= dv3_reg;
            sq_st_reg[0]   <= st3_reg;
        end
    end

    // One root bit per stage, restoring method.
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        logic [RMW-1:0] rem_in, trial;
        logic           ge;

        assign rem_in = {sq_rem_reg[k][RMW-3:0], sq_d_reg[k][DW-1:DW-2]};
        assign trial  = {sq_root_reg[k], 2'b01};
        assign ge     = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            if (en) begin
                sq_d_reg[k+1]    <= sq_d_reg[k] << 2;
                sq_rem_reg[k+1]  <= ge ? rem_in - trial : rem_in;
                sq_root_reg[k+1] <= {sq_root_reg[k][RW-2:0], ge};
                sq_xn_reg[k+1]   <= sq_xn_reg[k];
                sq_xm_reg[k+1]   <= sq_xm_reg[k];
                sq_dv_reg[k+1]   <= sq_dv_reg[k];
                sq_st_reg[k+1]   <= sq_st_reg[k];
            end
        end
    end

    // Two dividers side by side: root / 2A for y and |numerator| / 2A for x.
    logic           dv_v_reg  [1:W];
    logic [RW-1:0]  dv_yr_reg [1:W];
    logic [W-1:0]   dv_yq_reg [1:W];
    logic [XMW-1:0] dv_xr_reg [1:W];
    logic [W-1:0]   dv_xq_reg [1:W];
    logic           dv_xn_reg [1:W];
    logic [W:0]     dv_dv_reg [1:W];
    status_t        dv_st_reg [1:W];

    for (genvar j = 0; j < W; j++) begin : g_div
        logic           pv, pxn;
        logic [RW-1:0]  pyr, trial, xr_ext;
        logic [W-1:0]   pyq, pxq;
        logic [XMW-1:0] pxr;
        logic [W:0]     pdv;
        status_t        pst;
        logic           yge, xge;

        if (j == 0) begin : g_first
            assign pv  = sq_v_reg[RW];
            assign pyr = sq_root_reg[RW];
            assign pyq = '0;
            assign pxr = sq_xm_reg[RW];
            assign pxq = '0;
            assign pxn = sq_xn_reg[RW];
            assign pdv = sq_dv_reg[RW];
            assign pst = sq_st_reg[RW];
        end else begin : g_next
            assign pv  = dv_v_reg[j];
            assign pyr = dv_yr_reg[j];
            assign pyq = dv_yq_reg[j];
            assign pxr = dv_xr_reg[j];
            assign pxq = dv_xq_reg[j];
            assign pxn = dv_xn_reg[j];
            assign pdv = dv_dv_reg[j];
            assign pst = dv_st_reg[j];
        end

        // Divisor aligned to this quotient bit.
        assign trial  = RW'(pdv) << (W - 1 - j);
        assign xr_ext = RW'(pxr);
        assign yge    = pyr >= trial;
        assign xge    = xr_ext >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[j+1] <= pv;
            end
            if (en) begin
                dv_yr_reg[j+1] <= yge ? pyr - trial : pyr;
                dv_yq_reg[j+1] <= {pyq[W-2:0], yge};
                dv_xr_reg[j+1] <= xge ? XMW'(xr_ext - trial) : pxr;
                dv_xq_reg[j+1] <= {pxq[W-2:0], xge};
                dv_xn_reg[j+1] <= pxn;
                dv_dv_reg[j+1] <= pdv;
                dv_st_reg[j+1] <= pst;
            end
        end
    end

    // Output register: apply sign to x and clear both coordinates on error.
    logic        ok_last;
    logic [W:0]  x_mag, x_signed;

    assign ok_last  = dv_st_reg[W] == ST_OK;
    assign x_mag    = {1'b0, dv_xq_reg[W]};
    assign x_signed = dv_xn_reg[W] ? -x_mag : x_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en) begin
            m_tvalid <= dv_v_reg[W];
        end
        if (en) begin
            m_tdata <= {{PAD{1'b0}},
                        (ok_last ? dv_yq_reg[W] : {W{1'b0}}),
                        (ok_last ? x_signed : {(W+1){1'b0}})};
            m_tuser <= dv_st_reg[W];
        end
    end

endmodule

`default_nettype wire
